@@ sv/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants of the multi-turn servo path unit
// Field widths, angle constants, move codes and controller states.
// ----------------------------------------------------------------------------
package msp_pkg;

  // field widths
  localparam int CMD_W        = 12;
  localparam int POS_W        = 18;
  localparam int MAG_W        = POS_W - 1;
  localparam int KIND_W       = 3;
  localparam int DUTY_W       = 14;
  localparam int LIM_W        = 16;
  localparam int CT_W         = 13;
  localparam int DIST_W       = 13;
  localparam int DIFF_W       = 14;
  localparam int MOVE_W       = 20;
  localparam int NUM_W        = 30;
  localparam int QUOT_W       = 15;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_FIELDS_W = POS_W + KIND_W + DUTY_W;

  // angles in tenths of a degree, full duty in hundredths of a percent
  localparam int TURN_TENTHS      = 3600;
  localparam int HALF_TURN_TENTHS = 1800;
  localparam int DUTY_FULL        = 10000;
  localparam int POS_MIN          = -36000;
  localparam int POS_MAX          = 72000;

  localparam int START_POS_DEF = 0;

  localparam logic [LIM_W-1:0] LOW_LIMIT_RESET  = LIM_W'(0);
  localparam logic [LIM_W-1:0] HIGH_LIMIT_RESET = LIM_W'(36000);

  // configuration register indexes
  localparam logic REG_LOW_LIMIT  = 1'b0;
  localparam logic REG_HIGH_LIMIT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    MOVE_NONE      = 3'd0,
    MOVE_DOWN      = 3'd1,
    MOVE_UP        = 3'd2,
    MOVE_DOWN_TOP  = 3'd3,
    MOVE_UP_BOTTOM = 3'd4
  } move_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DIST,
    ST_MOVE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } ctrl_state_e;

  // handshake between the controller and a serial unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

@@ sv/msp_mod_turn.sv @@
// ----------------------------------------------------------------------------
// msp_mod_turn: serial remainder of the position modulo one turn
// Restoring reduction of the magnitude, one shifted multiple of a turn per
// cycle, sign of the position kept on the remainder.
// ----------------------------------------------------------------------------
module msp_mod_turn (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  msp_pkg::unit_req_t                 req_i,
  input  logic signed [msp_pkg::POS_W-1:0]   pos_i,
  output msp_pkg::unit_rsp_t                 rsp_o,
  output logic signed [msp_pkg::CT_W-1:0]    rem_o
);
  import msp_pkg::*;

  localparam int MOD_STEPS = 5;
  localparam int CNT_W     = $clog2(MOD_STEPS);
  localparam int SUB_W     = 16;
  localparam logic [SUB_W-1:0] SUB_INIT = SUB_W'(TURN_TENTHS << (MOD_STEPS - 1));

  logic [MAG_W-1:0]        mag_q, mag_d;
  logic [SUB_W-1:0]        sub_q, sub_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    neg_q, neg_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic signed [POS_W-1:0] pos_abs;
  logic [CT_W-1:0]         rem_mag;

  assign pos_abs = pos_i[POS_W-1] ? -pos_i : pos_i;

  always_comb begin
    mag_d  = mag_q;
    sub_d  = sub_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      mag_d  = pos_abs[MAG_W-1:0];
      neg_d  = pos_i[POS_W-1];
      sub_d  = SUB_INIT;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // take off the current multiple of a turn if it fits
      if (mag_q >= MAG_W'(sub_q)) begin
        mag_d = mag_q - MAG_W'(sub_q);
      end
      sub_d = sub_q >> 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(MOD_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    sub_q <= sub_d;
    neg_q <= neg_d;
  end

  assign rem_mag    = CT_W'(mag_q);
  assign rem_o      = neg_q ? -$signed(rem_mag) : $signed(rem_mag);
  assign rsp_o.done = done_q;

endmodule

@@ sv/msp_duty_div.sv @@
// ----------------------------------------------------------------------------
// msp_duty_div: bit-serial duty divider
// Restoring division of the scaled position by the high limit, one quotient
// bit per cycle, result saturated to full duty.
// ----------------------------------------------------------------------------
module msp_duty_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msp_pkg::unit_req_t            req_i,
  input  logic [msp_pkg::NUM_W-1:0]     num_i,
  input  logic [msp_pkg::LIM_W-1:0]     den_i,
  output msp_pkg::unit_rsp_t            rsp_o,
  output logic [msp_pkg::DUTY_W-1:0]    duty_o
);
  import msp_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic [LIM_W-1:0]  rem_q, rem_d;
  logic [LIM_W-1:0]  den_q, den_d;
  logic [QUOT_W-1:0] num_q, num_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              sat_q, sat_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [LIM_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, num_q[QUOT_W-1]};
  assign fits  = trial >= (LIM_W+1)'(den_q);

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    sat_d  = sat_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      den_d  = den_i;
      num_d  = num_i[QUOT_W-1:0];
      rem_d  = LIM_W'(num_i[NUM_W-1:QUOT_W]);
      quot_d = '0;
      cnt_d  = '0;
      // quotient would not fit the serial width: saturate at once
      if (LIM_W'(num_i[NUM_W-1:QUOT_W]) >= den_i) begin
        sat_d  = 1'b1;
        done_d = 1'b1;
      end else begin
        sat_d  = 1'b0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d  = fits ? LIM_W'(trial - (LIM_W+1)'(den_q)) : LIM_W'(trial);
      num_d  = num_q << 1;
      quot_d = {quot_q[QUOT_W-2:0], fits};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    sat_q  <= sat_d;
  end

  assign duty_o = (sat_q || quot_q > QUOT_W'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL)
                                                         : DUTY_W'(quot_q);
  assign rsp_o.done = done_q;

endmodule

@@ sv/multiturn_servo_shortest_path_unit.sv @@
// ----------------------------------------------------------------------------
// multiturn_servo_shortest_path_unit: multi-turn servo heading follower
// Follows heading commands the shortest way within travel limits and
// reports the new position, the move taken and the servo duty.
// ----------------------------------------------------------------------------
//  channel   direction  word contents (lowest bit first)
//  s_axis    in         heading_command[11:0], zero fill to 16 bits
//  m_axis    out        new_position[17:0], move_kind[20:18],
//                       duty_hundredths[34:21], zero fill to 40 bits
//  cfg       in         0 travel_low_limit, 1 travel_high_limit
//
//  a new command runs five modulo steps, the distance, move and product states,
//  fifteen divider steps and the output load; the divider ends at once when
//  the duty saturates and is skipped when the new position is not above zero
//  a repeated command is dropped in its accept cycle; the next command is
//  taken the cycle after a result loads, and a full output register stalls it
//  reset loads the start position, zeroes the last command, restores limits
// ----------------------------------------------------------------------------
module multiturn_servo_shortest_path_unit #(
  parameter int START_POSITION = msp_pkg::START_POS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [msp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // heading_command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [msp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // new_position,
                                                            // move_kind, duty
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [msp_pkg::LIM_W-1:0]         cfg_data_i
);
  import msp_pkg::*;

  localparam logic signed [MOVE_W-1:0] POS_MIN_W = MOVE_W'(POS_MIN);
  localparam logic signed [MOVE_W-1:0] POS_MAX_W = MOVE_W'(POS_MAX);

  ctrl_state_e state_q, state_d;

  logic [LIM_W-1:0]         low_q, high_q;
  logic signed [POS_W-1:0]  pos_q;
  logic [CMD_W-1:0]         last_q;
  logic signed [CMD_W-1:0]  cmd_q;
  logic [DIST_W-1:0]        down_q, up_q;
  logic                     pref_down_q, same_q;
  move_kind_e               kind_q;
  logic [NUM_W-1:0]         prod_q;
  logic [DUTY_W-1:0]        duty_q;
  logic signed [POS_W-1:0]  o_pos_q;
  move_kind_e               o_kind_q;
  logic [DUTY_W-1:0]        o_duty_q;
  logic                     o_valid_q;

  logic                     in_acc, cmd_new;
  logic                     load_out;
  unit_req_t                mod_req, div_req;
  unit_rsp_t                mod_rsp, div_rsp;
  logic signed [CT_W-1:0]   ct;
  logic [DUTY_W-1:0]        div_duty;

  // distance terms
  logic signed [CT_W-1:0]   tt;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W:0]   wrap_up, wrap_dn;
  logic [DIST_W-1:0]        down_c, up_c;
  logic                     pref_c;

  // move terms
  logic signed [MOVE_W-1:0] pos_w, lo_w, hi_w, dn_pos, up_pos, new_w;
  move_kind_e               kind_c;
  logic [NUM_W-1:0]         prod_c;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cmd_new = s_axis_tdata[CMD_W-1:0] != last_q;

  msp_mod_turn u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .pos_i  (pos_q),
    .rsp_o  (mod_rsp),
    .rem_o  (ct)
  );

  msp_duty_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (prod_q),
    .den_i  (high_q),
    .rsp_o  (div_rsp),
    .duty_o (div_duty)
  );

  // target shifted up by a half turn and the two ways around
  always_comb begin
    tt      = {cmd_q[CMD_W-1], cmd_q} + CT_W'(HALF_TURN_TENTHS);
    diff    = {ct[CT_W-1], ct} - {tt[CT_W-1], tt};
    wrap_up = (DIFF_W+1)'(TURN_TENTHS) - {diff[DIFF_W-1], diff};
    wrap_dn = (DIFF_W+1)'(TURN_TENTHS) + {diff[DIFF_W-1], diff};
    if (diff > 0) begin
      down_c = DIST_W'(diff);
      up_c   = wrap_up[DIFF_W] ? DIST_W'(-wrap_up) : DIST_W'(wrap_up);
      pref_c = down_c <= up_c;
    end else begin
      up_c   = DIST_W'(-diff);
      down_c = wrap_dn[DIFF_W] ? DIST_W'(-wrap_dn) : DIST_W'(wrap_dn);
      pref_c = down_c < up_c;
    end
  end

  // chosen way, limit refusal and saturation
  always_comb begin
    pos_w  = {{(MOVE_W-POS_W){pos_q[POS_W-1]}}, pos_q};
    lo_w   = $signed({{(MOVE_W-LIM_W){1'b0}}, low_q});
    hi_w   = $signed({{(MOVE_W-LIM_W){1'b0}}, high_q});
    dn_pos = pos_w - $signed({{(MOVE_W-DIST_W){1'b0}}, down_q});
    up_pos = pos_w + $signed({{(MOVE_W-DIST_W){1'b0}}, up_q});
    if (same_q) begin
      new_w  = pos_w;
      kind_c = MOVE_NONE;
    end else if (pref_down_q) begin
      if (dn_pos <= lo_w) begin
        new_w  = up_pos;
        kind_c = MOVE_UP_BOTTOM;
      end else begin
        new_w  = dn_pos;
        kind_c = MOVE_DOWN;
      end
    end else begin
      if (up_pos >= hi_w) begin
        new_w  = dn_pos;
        kind_c = MOVE_DOWN_TOP;
      end else begin
        new_w  = up_pos;
        kind_c = MOVE_UP;
      end
    end
    if (new_w < POS_MIN_W) begin
      new_w = POS_MIN_W;
    end else if (new_w > POS_MAX_W) begin
      new_w = POS_MAX_W;
    end
  end

  assign prod_c = NUM_W'(pos_q[MAG_W-1:0]) * NUM_W'(DUTY_FULL);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && cmd_new) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_rsp.done) begin
          state_d = ST_DIST;
        end
      end
      ST_DIST:      state_d = ST_MOVE;
      ST_MOVE:      state_d = ST_MUL;
      ST_MUL:       state_d = (pos_q > 0) ? ST_DIV_START : ST_OUT;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!o_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mod_req.start = 1'b0;
    div_req.start = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mod_req.start = s_axis_tvalid && cmd_new;
      end
      ST_DIV_START: div_req.start = 1'b1;
      ST_OUT:       load_out = !o_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      low_q     <= LOW_LIMIT_RESET;
      high_q    <= HIGH_LIMIT_RESET;
      pos_q     <= POS_W'(START_POSITION);
      last_q    <= '0;
      o_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOW_LIMIT:  low_q  <= cfg_data_i;
          REG_HIGH_LIMIT: high_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc && cmd_new) begin
        last_q <= s_axis_tdata[CMD_W-1:0];
      end
      if (state_q == ST_MOVE) begin
        pos_q <= POS_W'(new_w);
      end
      if (load_out) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= s_axis_tdata[CMD_W-1:0];
    end
    if (state_q == ST_DIST) begin
      down_q      <= down_c;
      up_q        <= up_c;
      pref_down_q <= pref_c;
      same_q      <= diff == '0;
    end
    if (state_q == ST_MOVE) begin
      kind_q <= kind_c;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_c;
      duty_q <= '0;
    end
    if (state_q == ST_DIV_WAIT && div_rsp.done) begin
      duty_q <= div_duty;
    end
    if (load_out) begin
      o_pos_q  <= pos_q;
      o_kind_q <= kind_q;
      o_duty_q <= duty_q;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-OUT_FIELDS_W)'(0), o_duty_q, o_kind_q, o_pos_q};

  // checks on the result and the modulo unit
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> (o_pos_q >= POS_W'(POS_MIN) && o_pos_q <= POS_W'(POS_MAX)))
    else $error("result position out of range");

  a_duty_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> o_duty_q <= DUTY_W'(DUTY_FULL))
    else $error("duty above full scale");

  a_duty_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_duty_q != '0) |-> o_pos_q > 0)
    else $error("nonzero duty at a position not above zero");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (ct > -CT_W'(TURN_TENTHS) && ct < CT_W'(TURN_TENTHS)))
    else $error("remainder not within one turn");

endmodule
